### sv/avr_rel_pkg.sv
// shared types and constants for the avr elf relocation patcher
// no dependencies; imported by every module of the block
`default_nettype none

package avr_rel_pkg;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned DYN_W     = 16;
    localparam int unsigned KIND_W    = 5;
    localparam int unsigned LEN_W     = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned K_W       = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECT = 1'b1;

    // relocation types, avr elf abi numbering
    localparam logic [KIND_W-1:0] K_NONE        = 5'd0;
    localparam logic [KIND_W-1:0] K_32          = 5'd1;
    localparam logic [KIND_W-1:0] K_7_PCREL     = 5'd2;
    localparam logic [KIND_W-1:0] K_13_PCREL    = 5'd3;
    localparam logic [KIND_W-1:0] K_16          = 5'd4;
    localparam logic [KIND_W-1:0] K_16_PM       = 5'd5;
    localparam logic [KIND_W-1:0] K_LO8_LDI     = 5'd6;
    localparam logic [KIND_W-1:0] K_HI8_LDI     = 5'd7;
    localparam logic [KIND_W-1:0] K_HH8_LDI     = 5'd8;
    localparam logic [KIND_W-1:0] K_LO8_LDI_NEG = 5'd9;
    localparam logic [KIND_W-1:0] K_HI8_LDI_NEG = 5'd10;
    localparam logic [KIND_W-1:0] K_HH8_LDI_NEG = 5'd11;
    localparam logic [KIND_W-1:0] K_LO8_LDI_PM  = 5'd12;
    localparam logic [KIND_W-1:0] K_HI8_LDI_PM  = 5'd13;
    localparam logic [KIND_W-1:0] K_HH8_LDI_PM  = 5'd14;
    localparam logic [KIND_W-1:0] K_LO8_PM_NEG  = 5'd15;
    localparam logic [KIND_W-1:0] K_HI8_PM_NEG  = 5'd16;
    localparam logic [KIND_W-1:0] K_HH8_PM_NEG  = 5'd17;
    localparam logic [KIND_W-1:0] K_CALL        = 5'd18;

    // write lengths
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_HALF = 3'd2;
    localparam logic [LEN_W-1:0] LEN_FULL = 3'd4;

    // status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_NO_DYN  = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [ADDR_W-1:0]        site_offset;
        logic [ADDR_W-1:0]        symbol_value;
        logic signed [ADDR_W-1:0] addend;
        logic                     is_dynamic_function;
        logic [DYN_W-1:0]         dynamic_address;
        logic [ADDR_W-1:0]        original_word;
    } t_rel_in;

    typedef struct packed {
        logic                     status;
        logic [LEN_W-1:0]         write_length;
        logic [ADDR_W-1:0]        write_offset;
        logic [ADDR_W-1:0]        patched_word;
    } t_rel_out;

    // resolved target handed from address unit to patch unit
    typedef struct packed {
        logic                     status;
        logic [ADDR_W-1:0]        addr;
        logic [ADDR_W-1:0]        neg;
        logic [K_W-1:0]           pcrel_k;
    } t_addr_info;

endpackage

`default_nettype wire

### sv/avr_rel_addr.sv
// target address resolution: absolute sum, dynamic address, negation, pc-relative offset
// depends on avr_rel_pkg
`default_nettype none

module avr_rel_addr (
    input  avr_rel_pkg::t_rel_in                 i_rel,
    input  logic [avr_rel_pkg::ADDR_W-1:0]       i_base_sect,
    output avr_rel_pkg::t_addr_info              o_info
);
    import avr_rel_pkg::*;

    logic [ADDR_W-1:0] sym_add;
    logic [ADDR_W-1:0] abs_addr;
    logic [K_W-1:0]    tgt_w;
    logic [K_W-1:0]    pc_w;

    always_comb begin
        sym_add  = i_rel.symbol_value + ADDR_W'(unsigned'(i_rel.addend));
        abs_addr = i_base_sect + sym_add;
        // word addresses for the relative jump
        tgt_w    = sym_add[K_W:1];
        pc_w     = i_rel.site_offset[K_W:1];

        if (i_rel.is_dynamic_function) begin
            o_info.addr   = {{(ADDR_W-DYN_W){1'b0}}, i_rel.dynamic_address};
            o_info.status = (i_rel.dynamic_address == '0) ? ST_NO_DYN : ST_OK;
        end else begin
            o_info.addr   = abs_addr;
            o_info.status = ST_OK;
        end
        o_info.neg     = '0 - o_info.addr;
        o_info.pcrel_k = tgt_w - pc_w - K_W'(1);
    end

endmodule

`default_nettype wire

### sv/avr_rel_patch.sv
// instruction byte patching per relocation type
// depends on avr_rel_pkg
`default_nettype none

module avr_rel_patch (
    input  logic [avr_rel_pkg::KIND_W-1:0]  i_kind,
    input  logic [avr_rel_pkg::ADDR_W-1:0]  i_word,
    input  avr_rel_pkg::t_addr_info         i_info,
    output logic [avr_rel_pkg::LEN_W-1:0]   o_len,
    output logic [avr_rel_pkg::ADDR_W-1:0]  o_word
);
    import avr_rel_pkg::*;

    logic [ADDR_W-1:0] addr_sh1;
    logic [ADDR_W-1:0] neg_sh1;
    logic [7:0]        ldi_v;
    logic [ADDR_W-1:0] ldi_word;
    logic [ADDR_W-1:0] word;
    logic [LEN_W-1:0]  len;

    always_comb begin
        addr_sh1 = i_info.addr >> 1;
        neg_sh1  = i_info.neg >> 1;
        word     = i_word;
        len      = LEN_HALF;
        ldi_v    = '0;

        case (i_kind)
            K_LO8_LDI:     ldi_v = i_info.addr[7:0];
            K_HI8_LDI:     ldi_v = i_info.addr[15:8];
            K_HH8_LDI:     ldi_v = i_info.addr[23:16];
            K_LO8_LDI_NEG: ldi_v = i_info.neg[7:0];
            K_HI8_LDI_NEG: ldi_v = i_info.neg[15:8];
            K_HH8_LDI_NEG: ldi_v = i_info.neg[23:16];
            K_LO8_LDI_PM:  ldi_v = addr_sh1[7:0];
            K_HI8_LDI_PM:  ldi_v = addr_sh1[15:8];
            K_HH8_LDI_PM:  ldi_v = addr_sh1[23:16];
            K_LO8_PM_NEG:  ldi_v = neg_sh1[7:0];
            K_HI8_PM_NEG:  ldi_v = neg_sh1[15:8];
            K_HH8_PM_NEG:  ldi_v = neg_sh1[23:16];
            default:       ldi_v = '0;
        endcase

        // ldi immediate: low nibble of each of the two opcode bytes
        ldi_word = {i_word[31:12], ldi_v[7:4], i_word[7:4], ldi_v[3:0]};

        case (i_kind)
            K_NONE, K_32, K_7_PCREL: begin
                len = LEN_NONE;
            end
            K_13_PCREL: begin
                word = {i_word[31:12], i_info.pcrel_k[11:0]};
            end
            K_16: begin
                word = {i_word[31:16], i_info.addr[15:0]};
            end
            K_16_PM: begin
                word = {i_word[31:16], addr_sh1[15:0]};
            end
            K_LO8_LDI, K_HI8_LDI, K_HH8_LDI,
            K_LO8_LDI_NEG, K_HI8_LDI_NEG, K_HH8_LDI_NEG,
            K_LO8_LDI_PM, K_HI8_LDI_PM, K_HH8_LDI_PM,
            K_LO8_PM_NEG, K_HI8_PM_NEG, K_HH8_PM_NEG: begin
                word = ldi_word;
            end
            K_CALL: begin
                word = {addr_sh1[15:0], i_word[15:0]};
                len  = LEN_FULL;
            end
            default: begin
                len = LEN_NONE;
            end
        endcase

        // missing dynamic address: nothing written
        if (i_info.status == ST_NO_DYN) begin
            len = LEN_NONE;
        end
        o_len  = len;
        o_word = (len == LEN_NONE) ? i_word : word;
    end

endmodule

`default_nettype wire

### sv/avr_elf_relocation_patcher.sv
// top level of the avr elf relocation patcher: config registers, input and result stages
// depends on avr_rel_pkg, avr_rel_addr, avr_rel_patch
//
//   port group   direction  handshake                 payload
//   in           sink       i_in_valid / o_in_stall   i_in_data  (t_rel_in)
//   out          source     o_out_valid / i_out_stall o_out_data (t_rel_out)
//   cfg          sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one transaction per cycle sustained while i_out_stall stays low; an accepted
// transaction passes the input register, then the result register, and is held
// in the result register while i_out_stall is high
// the path between the two registers is two 32-bit adds and a negation in series,
// plus byte selection
// synchronous active-low reset clears valids, the two config registers and their sum
// a stalled result holds its register; the input stage keeps taking transactions
// until both stages are full, then o_in_stall rises
`default_nettype none

module avr_elf_relocation_patcher (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  avr_rel_pkg::t_rel_in                  i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output avr_rel_pkg::t_rel_out                 o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [avr_rel_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [avr_rel_pkg::ADDR_W-1:0]        i_cfg_data
);
    import avr_rel_pkg::*;

    // configuration
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_sect;
    logic [ADDR_W-1:0] r_base_sect;   // base plus section, updated with each register write

    // input stage
    logic              r_s1_valid;
    t_rel_in           r_s1;

    // result stage
    logic              r_out_valid;
    t_rel_out          r_out;
    t_rel_out          n_out;

    logic              out_ready;
    logic              s1_ready;
    logic              in_take;
    logic              s1_move;

    t_addr_info        info;
    logic [LEN_W-1:0]  patch_len;
    logic [ADDR_W-1:0] patch_word;

    // handshake: result register frees when empty or taken downstream
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_ready;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign o_in_stall = !s1_ready;
    assign in_take    = i_in_valid && s1_ready;

    // precomputed sum so the per-transaction path carries one fewer adder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_sect      <= '0;
            r_base_sect <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE: begin
                    r_base      <= i_cfg_data;
                    r_base_sect <= i_cfg_data + r_sect;
                end
                CFG_SECT: begin
                    r_sect      <= i_cfg_data;
                    r_base_sect <= r_base + i_cfg_data;
                end
                default:  r_base <= r_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1 <= i_in_data;
        end
    end

    avr_rel_addr u_addr (
        .i_rel       (r_s1),
        .i_base_sect (r_base_sect),
        .o_info      (info)
    );

    avr_rel_patch u_patch (
        .i_kind (r_s1.kind),
        .i_word (r_s1.original_word),
        .i_info (info),
        .o_len  (patch_len),
        .o_word (patch_word)
    );

    always_comb begin
        n_out.status       = info.status;
        n_out.write_length = patch_len;
        n_out.write_offset = r_sect + r_s1.site_offset;
        n_out.patched_word = patch_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // upstream is only held off while the input stage holds a transaction
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty input stage");

    // a result appears only after a transaction sat in the input stage
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result valid without a source transaction");

    // lengths are none, half or full
    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.write_length == LEN_NONE ||
                         r_out.write_length == LEN_HALF ||
                         r_out.write_length == LEN_FULL))
        else $error("illegal write length");

    // a failed dynamic lookup never writes
    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_NO_DYN) |-> (r_out.write_length == LEN_NONE))
        else $error("write requested on failed dynamic lookup");

endmodule

`default_nettype wire
